@@ hw/rtl/hpt_pkg.sv @@
package hpt_pkg;

    // Result coordinate width and quotient width before rounding
    // (one extra bit carries the rounding half step).
    localparam int OUT_W  = 32;
    localparam int QUOT_W = OUT_W + 1;

    // Configuration register width and index codes
    localparam int CFG_W    = 63;
    localparam int CFG_AW   = 3;
    localparam logic [CFG_AW-1:0] REG_FWD_ROW0  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_FWD_ROW1  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FWD_ROW2  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_INV_ROW0  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_INV_ROW1  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_INV_ROW2  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_FRAC_BITS = 3'd6;

    // Identity matrix after reset uses 12 coefficient fraction bits
    localparam int ID_FRAC = 12;

    // Saturation limits on the magnitude of the rounded quotient
    localparam logic [QUOT_W-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
    localparam logic [QUOT_W-1:0] NEG_LIMIT = 33'h0_8000_0000;
    localparam logic [OUT_W-1:0]  OUT_MAX   = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0]  OUT_MIN   = 32'h8000_0000;

    // Side information that travels alongside the divider lanes
    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic zero;
    } hpt_tag_t;

endpackage

@@ hw/rtl/hpt_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// quot = floor(num * 2^(FRAC_BITS+1) / den), ovf when that is >= 2^QUOT_W.
module hpt_divider #(
    parameter int MAG_W     = 55,
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic [MAG_W-1:0]              num,
    input  logic [MAG_W-1:0]              den,
    output logic [hpt_pkg::QUOT_W-1:0]    quot,
    output logic                          ovf
);
    localparam int QW = hpt_pkg::QUOT_W;
    localparam int SH = QW - FRAC_BITS - 1;

    logic [MAG_W-1:0] rem_reg [0:QW];
    logic [MAG_W-1:0] num_reg [0:QW];
    logic [MAG_W-1:0] den_reg [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];
    logic             ovf_reg [0:QW];

    // Entry stage: high part of the dividend and the overflow test
    always_ff @(posedge aclk) begin
        if (ce) begin
            num_reg[0] <= num;
            den_reg[0] <= den;
            rem_reg[0] <= num >> SH;
            ovf_reg[0] <= (num >> SH) >= den;
            q_reg[0]   <= '0;
        end
    end

    // One compare and subtract per stage, MSB of the quotient first
    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int BI = QW - 1 - j;
        logic             nbit;
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        logic             ge;

        if (BI >= FRAC_BITS + 1) begin : g_nb
            assign nbit = num_reg[j][BI-FRAC_BITS-1];
        end else begin : g_zb
            assign nbit = 1'b0;
        end

        assign trial = {rem_reg[j], nbit};
        assign diff  = trial - {1'b0, den_reg[j]};
        assign ge    = trial >= {1'b0, den_reg[j]};

        always_ff @(posedge aclk) begin
            if (ce) begin
                num_reg[j+1] <= num_reg[j];
                den_reg[j+1] <= den_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                rem_reg[j+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                q_reg[j+1]   <= {q_reg[j][QW-2:0], ge};
            end
        end
    end

    assign quot = q_reg[QW];
    assign ovf  = ovf_reg[QW];

endmodule

@@ hw/rtl/homography_point_transform.sv @@
// Projective point transform through a 3x3 homography.
// Pipeline: 39 register stages (3 dot-product, 34 divider, 1 rounding, 1 output).
// Throughput: one point per cycle while s_tready is high (bit-per-stage divider pipeline).
// Reset (aresetn low, synchronous): pipeline and output emptied, every matrix
// set to identity with 12 fraction bits.
module homography_point_transform #(
    parameter int COEF_WIDTH      = 21,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Config write port
    input  logic                          cfg_we,
    input  logic [hpt_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [hpt_pkg::CFG_W-1:0]     cfg_wdata,
    // Input points
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // x_in[31:0], y_in[63:32]
    input  logic                          s_tuser,   // kind
    // Result points
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // x_out[31:0], y_out[63:32]
    output logic [1:0]                    m_tuser    // zero_divisor[0], saturated[1]
);
    localparam int CW = COEF_WIDTH;
    localparam int F  = COORD_FRAC_BITS;
    localparam int PW = CW + 32;
    localparam int SW = CW + 34;
    localparam int QW = hpt_pkg::QUOT_W;
    localparam int OW = hpt_pkg::OUT_W;
    localparam int RW = hpt_pkg::CFG_W;

    // ---------------- config registers ----------------
    logic [RW-1:0] fwd_reg [0:2];
    logic [RW-1:0] inv_reg [0:2];

    // The coefficient fraction count cancels in the divide; index 6 is accepted and dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                fwd_reg[k] <= RW'(1) << (k * CW + hpt_pkg::ID_FRAC);
                inv_reg[k] <= RW'(1) << (k * CW + hpt_pkg::ID_FRAC);
            end
        end else if (cfg_we) begin
            case (cfg_addr)
                hpt_pkg::REG_FWD_ROW0: fwd_reg[0] <= cfg_wdata;
                hpt_pkg::REG_FWD_ROW1: fwd_reg[1] <= cfg_wdata;
                hpt_pkg::REG_FWD_ROW2: fwd_reg[2] <= cfg_wdata;
                hpt_pkg::REG_INV_ROW0: inv_reg[0] <= cfg_wdata;
                hpt_pkg::REG_INV_ROW1: inv_reg[1] <= cfg_wdata;
                hpt_pkg::REG_INV_ROW2: inv_reg[2] <= cfg_wdata;
                hpt_pkg::REG_FRAC_BITS: ;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    logic ce;
    logic skid_valid_reg;
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // ---------------- stage 1: products ----------------
    logic signed [31:0] x_in, y_in;
    assign x_in = $signed(s_tdata[31:0]);
    assign y_in = $signed(s_tdata[63:32]);

    logic signed [PW-1:0] px_reg [0:2];
    logic signed [PW-1:0] py_reg [0:2];
    logic signed [SW-1:0] pc_reg [0:2];
    logic                 v1_reg;

    for (genvar k = 0; k < 3; k++) begin : g_row
        logic [RW-1:0]        row;
        logic signed [CW-1:0] ca, cb, cc;
        logic signed [PW-1:0] pa, pb;
        logic signed [SW-1:0] pc;

        assign row = s_tuser ? inv_reg[k] : fwd_reg[k];
        assign ca  = $signed(row[0 +: CW]);
        assign cb  = $signed(row[CW +: CW]);
        assign cc  = $signed(row[2*CW +: CW]);
        assign pa  = ca * x_in;
        assign pb  = cb * y_in;
        assign pc  = SW'(cc) <<< F;

        always_ff @(posedge aclk) begin
            if (ce) begin
                px_reg[k] <= pa;
                py_reg[k] <= pb;
                pc_reg[k] <= pc;
            end
        end
    end

    // ---------------- stage 2: row sums ----------------
    logic signed [SW-1:0] sum_reg [0:2];
    logic                 v2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= SW'(px_reg[k]) + SW'(py_reg[k]) + pc_reg[k];
            end
        end
    end

    // ---------------- stage 3: magnitudes and signs ----------------
    logic [SW-1:0]     mag_reg [0:2];
    hpt_pkg::hpt_tag_t tag3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag3_reg.valid <= 1'b0;
        end else if (ce) begin
            tag3_reg.valid <= v2_reg;
        end
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= sum_reg[k][SW-1] ? SW'(-sum_reg[k]) : SW'(sum_reg[k]);
            end
            tag3_reg.neg_x <= sum_reg[0][SW-1] ^ sum_reg[2][SW-1];
            tag3_reg.neg_y <= sum_reg[1][SW-1] ^ sum_reg[2][SW-1];
            tag3_reg.zero  <= (sum_reg[2] == '0);
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    // ---------------- divider lanes ----------------
    logic [QW-1:0] qx, qy;
    logic          ovx, ovy;

    hpt_divider #(.MAG_W(SW), .FRAC_BITS(F)) u_div_x (
        .aclk (aclk), .ce (ce), .num (mag_reg[0]), .den (mag_reg[2]),
        .quot (qx), .ovf (ovx)
    );

    hpt_divider #(.MAG_W(SW), .FRAC_BITS(F)) u_div_y (
        .aclk (aclk), .ce (ce), .num (mag_reg[1]), .den (mag_reg[2]),
        .quot (qy), .ovf (ovy)
    );

    // Tag delay line matching the divider latency
    hpt_pkg::hpt_tag_t tag_reg [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QW; i++) begin
                tag_reg[i] <= '0;
            end
        end else if (ce) begin
            tag_reg[0] <= tag3_reg;
            for (int i = 1; i <= QW; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // ---------------- rounding and clamp ----------------
    logic [QW:0]    rx_sum, ry_sum;
    logic [QW-1:0]  rx, ry;
    logic           satx, saty;
    logic [OW-1:0]  ox, oy;
    hpt_pkg::hpt_tag_t tf;

    assign tf     = tag_reg[QW];
    assign rx_sum = {1'b0, qx} + (QW+1)'(1);
    assign ry_sum = {1'b0, qy} + (QW+1)'(1);
    assign rx     = rx_sum[QW:1];
    assign ry     = ry_sum[QW:1];
    assign satx   = ovx || (tf.neg_x ? (rx > hpt_pkg::NEG_LIMIT) : (rx > hpt_pkg::POS_LIMIT));
    assign saty   = ovy || (tf.neg_y ? (ry > hpt_pkg::NEG_LIMIT) : (ry > hpt_pkg::POS_LIMIT));

    always_comb begin
        if (satx) begin
            ox = tf.neg_x ? hpt_pkg::OUT_MIN : hpt_pkg::OUT_MAX;
        end else begin
            ox = tf.neg_x ? OW'(-rx) : rx[OW-1:0];
        end
        if (saty) begin
            oy = tf.neg_y ? hpt_pkg::OUT_MIN : hpt_pkg::OUT_MAX;
        end else begin
            oy = tf.neg_y ? OW'(-ry) : ry[OW-1:0];
        end
    end

    logic         fin_valid_reg;
    logic [63:0]  fin_data_reg;
    logic [1:0]   fin_user_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (tf.zero) begin
                fin_data_reg <= '0;
                fin_user_reg <= 2'b01;
            end else begin
                fin_data_reg <= {oy, ox};
                fin_user_reg <= {satx | saty, 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (ce) begin
            fin_valid_reg <= tf.valid;
        end
    end

    // ---------------- output register with skid stage ----------------
    logic         out_valid_reg;
    logic [63:0]  out_data_reg;
    logic [1:0]   out_user_reg;
    logic [63:0]  skid_data_reg;
    logic [1:0]   skid_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (ce) begin
            // Final stage drains this cycle
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= fin_valid_reg;
                out_data_reg  <= fin_data_reg;
                out_user_reg  <= fin_user_reg;
            end else begin
                skid_valid_reg <= fin_valid_reg;
                skid_data_reg  <= fin_data_reg;
                skid_user_reg  <= fin_user_reg;
            end
        end else if (m_tready) begin
            // Pipeline held; move the parked beat forward
            out_valid_reg  <= 1'b1;
            out_data_reg   <= skid_data_reg;
            out_user_reg   <= skid_user_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
